FILE: rtl/spq_pkg.sv
package spq_pkg;

    localparam int KEY_W  = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    typedef logic signed [KEY_W-1:0] key_t;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_POP     = 2'd2,
        KIND_REPLACE = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_POP
    } cell_op_t;

    // The compare key travels on its own wire, apart from the operation
    typedef struct packed {
        cell_op_t op;
        logic     found;   // delete only: some cell matched the key
    } cell_cmd_t;

    // Per-cell compare results
    typedef struct packed {
        logic gt;   // empty or entry > key: insert point is at or before here
        logic ge;   // empty or entry >= key: delete shift starts at or before here
        logic eq;   // holds an entry equal to key
    } cell_flags_t;

    typedef enum logic {
        S_IDLE,
        S_REPL
    } state_t;

endpackage

FILE: rtl/sorted_priority_queue_top.sv
// Sorted priority queue of signed 32-bit keys, held in ascending order in a
// row of CAPACITY identical cells; equal keys leave in arrival order. Each
// cell compares its entry with the broadcast key and either holds or takes
// its left or right neighbor's entry, so the whole list shifts in parallel.
// Insert, delete, and remove-minimum each make a single pass; replace makes two
// (a delete pass, then an insert pass through the same cell row). A new
// request is taken in the same cycle the previous response is taken, so with
// rsp_ready high the queue sustains one request per cycle except replace. Every
// request returns one response: status, removed key (zero if none), the
// head key after the operation (zero when empty) and the occupancy, which
// wraps modulo 32 for capacities above 31. Insert into a full queue is
// dropped with a full status; delete or remove-minimum on an empty queue
// returns an empty status. The queue is empty after reset; no clearing pass.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic signed [KEY_W-1:0] key,
    input  logic signed [KEY_W-1:0] new_key,
    // response channel
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [STAT_W-1:0]    status,
    output logic signed [KEY_W-1:0] removed_key,
    output logic signed [KEY_W-1:0] smallest_key,
    output logic [OCC_W-1:0]     occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    status_t       status_reg;
    status_t       status_next;
    key_t          removed_reg;
    key_t          removed_next;
    key_t          new_key_reg;
    key_t          new_key_next;

    logic          accept;
    kind_t         req_kind;
    cell_cmd_t     cmd;
    key_t          cmp_key;

    key_t          entry_vec [CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    cell_flags_t   flags_vec [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic          found;
    logic          empty;
    logic          full;

    // A request enters only when the response slot is free or draining now.
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign req_kind  = kind_t'(kind);

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CAP_CNT);

    // Compare key: the request key, or the held new key on the replace insert pass
    assign cmp_key = (state_reg == S_REPL) ? new_key_reg : key;

    // Global match for delete; the first match leads the ge region since the
    // row is sorted, so shifting every ge cell removes exactly that entry.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            eq_vec[i] = flags_vec[i].eq;
        end
    end
    assign found = |eq_vec;

    //--------------------------------------------------------------------
    // Cell row
    //--------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            key_t left_entry;
            logic left_valid;
            logic left_gt;
            key_t right_entry;
            logic right_valid;

            if (g == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_valid = 1'b0;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_mid_l
                assign left_entry = entry_vec[g-1];
                assign left_valid = valid_vec[g-1];
                assign left_gt    = flags_vec[g-1].gt;
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_entry = entry_vec[g+1];
                assign right_valid = valid_vec[g+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key         (cmp_key),
                .left_entry  (left_entry),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .right_entry (right_entry),
                .right_valid (right_valid),
                .entry       (entry_vec[g]),
                .valid       (valid_vec[g]),
                .flags       (flags_vec[g])
            );
        end
    endgenerate

    //--------------------------------------------------------------------
    // Next state
    //--------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_kind == KIND_REPLACE))
                begin
                    state_next = S_REPL;
                end
            end
            S_REPL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    //--------------------------------------------------------------------
    // Cell command, count and response
    //--------------------------------------------------------------------
    always_comb
    begin
        cmd.op         = OP_HOLD;
        cmd.found      = found;
        count_next     = count_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        new_key_next   = new_key_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = STAT_OK;
                    removed_next = '0;
                    unique case (req_kind)
                        KIND_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                cmd.op     = OP_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        KIND_DELETE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else if (found)
                            begin
                                cmd.op       = OP_DELETE;
                                removed_next = key;
                                count_next   = count_reg - CW'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                        KIND_POP:
                        begin
                            rsp_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.op       = OP_POP;
                                removed_next = entry_vec[0];
                                count_next   = count_reg - CW'(1);
                            end
                        end
                        KIND_REPLACE:
                        begin
                            // delete pass; insert follows in S_REPL
                            new_key_next = new_key;
                            if (found)
                            begin
                                cmd.op       = OP_DELETE;
                                removed_next = key;
                                count_next   = count_reg - CW'(1);
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_REPL:
            begin
                rsp_valid_next = 1'b1;
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        new_key_reg <= new_key_next;
    end

    // Head comes straight from the cell row, occupancy from the count: neither
    // changes while a response waits, as a request enters only as it leaves.
    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign removed_key  = removed_reg;
    assign smallest_key = valid_vec[0] ? entry_vec[0] : '0;
    assign occupancy    = OCC_W'(count_reg);

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[0] == !empty)
        else $error("head cell valid does not follow occupancy");

    a_repl_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_kind == KIND_REPLACE)) |=> (state_reg == S_REPL))
        else $error("replace did not enter its insert pass");

    a_repl_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPL) |-> !rsp_valid_reg)
        else $error("response pending during replace insert pass");

endmodule

FILE: rtl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_cmd_t   cmd,
    input  key_t        key,
    input  key_t        left_entry,
    input  logic        left_valid,
    input  logic        left_gt,
    input  key_t        right_entry,
    input  logic        right_valid,
    output key_t        entry,
    output logic        valid,
    output cell_flags_t flags
);

    key_t entry_reg;
    key_t entry_next;
    logic valid_reg;
    logic valid_next;

    always_comb
    begin
        flags.gt = !valid_reg || (entry_reg > key);
        flags.ge = !valid_reg || (entry_reg >= key);
        flags.eq = valid_reg && (entry_reg == key);
    end

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                // Cells past the insert point move one place right
                if (flags.gt)
                begin
                    if (left_gt)
                    begin
                        entry_next = left_entry;
                        valid_next = left_valid;
                    end
                    else
                    begin
                        entry_next = key;
                        valid_next = 1'b1;
                    end
                end
            end
            OP_DELETE:
            begin
                if (cmd.found && flags.ge)
                begin
                    entry_next = right_entry;
                    valid_next = right_valid;
                end
            end
            OP_POP:
            begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule
